// ----- sv/egbl_pkg.sv -----
// Shared types and constants for the elevation grid lookup core.
// Used by every module and interface of the block; no dependencies.
`default_nettype none
package egbl_pkg;

  localparam int MAX_ROWS_DEF  = 256;
  localparam int MAX_COLS_DEF  = 256;
  localparam int FRAC_BITS_DEF = 8;

  localparam int COORD_W    = 31;
  localparam int INV_W      = 32;
  localparam int CNT_W      = 9;
  localparam int ELEV_W     = 16;
  localparam int ALT_W      = 24;
  localparam int CELL_W     = 8;
  localparam int OP_W       = 2;
  localparam int POS_SHIFT  = 38;
  localparam int POS_W      = COORD_W + INV_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ALT_MAX    = 8388607;
  localparam int ALT_MIN    = -8388608;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE    = 2'd0,
    OP_NEAREST  = 2'd1,
    OP_BILINEAR = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOUTH_LAT = 3'd0,
    REG_NORTH_LAT = 3'd1,
    REG_WEST_LON  = 3'd2,
    REG_EAST_LON  = 3'd3,
    REG_INV_CELL  = 3'd4,
    REG_NUM_ROWS  = 3'd5,
    REG_NUM_COLS  = 3'd6,
    REG_NODATA    = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic vld;
    op_e  op;
    logic outside;
    logic wr_en;
  } ctl_t;

endpackage
`default_nettype wire

// ----- sv/egbl_if.sv -----
// Request and result channel interfaces of the elevation grid lookup core.
// Depends on egbl_pkg for field widths.
`default_nettype none
interface egbl_in_if import egbl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [COORD_W-1:0] lat;
  logic signed [COORD_W-1:0] lon;
  logic [CELL_W-1:0]        cell_row;
  logic [CELL_W-1:0]        cell_col;
  logic signed [ELEV_W-1:0] elevation;

  modport source (output valid, op, lat, lon, cell_row, cell_col, elevation, input ready);
  modport sink (input valid, op, lat, lon, cell_row, cell_col, elevation, output ready);
endinterface

interface egbl_out_if import egbl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ALT_W-1:0] altitude;
  logic                    outside;

  modport source (output valid, altitude, outside, input ready);
  modport sink (input valid, altitude, outside, output ready);
endinterface
`default_nettype wire

// ----- sv/elevation_grid_bilinear_lookup_core.sv -----
// Elevation grid lookup core: a grid of signed 16-bit samples loaded by
// write requests and sampled by nearest or bilinear query requests.
// Channels: in_ch carries requests (op, lat, lon, cell_row, cell_col,
// elevation), out_ch carries results (altitude with FRAC_BITS fraction
// bits, outside flag). Both use valid/ready; a request moves on a clock
// edge with valid and ready high. cfg_wr_en/cfg_index/cfg_data write the
// box bounds, reciprocal cell size, grid size and nodata value.
// Throughput: one request per cycle while out_ch is not stalled. A query
// result reaches out_ch through six register stages (bounds, multiply,
// index split, bank read, products, sum). Write requests and op 3 give no
// result. Four parity banks let all four bilinear neighbours read in the
// same cycle.
// Reset: synchronous, active low; the pipeline empties and registers take
// their defaults. The grid is not cleared and holds nothing defined until
// written. When the receiver stalls, the result holds and stages fill
// behind it; in_ch.ready drops only once every stage is occupied or in reset.
// Depends on egbl_pkg, egbl_if, egbl_pos, egbl_grid and egbl_blend.
`default_nettype none
module elevation_grid_bilinear_lookup_core import egbl_pkg::*; #(
  parameter int MAX_ROWS  = MAX_ROWS_DEF,
  parameter int MAX_COLS  = MAX_COLS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  egbl_in_if.sink              in_ch,
  egbl_out_if.source           out_ch,
  input  wire                  cfg_wr_en,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0] cfg_data
);

  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int WP_W  = 2 * FRAC_BITS + 2;

  logic signed [COORD_W-1:0] south_r, north_r, west_r, east_r;
  logic [INV_W-1:0]          inv_r;
  logic [CNT_W-1:0]          rows_r, cols_r;
  logic signed [ELEV_W-1:0]  nodata_r;
  logic [ROW_W-1:0]          last_row;
  logic [COL_W-1:0]          last_col;

  ctl_t                     pos_ctl, grid_ctl;
  logic                     grid_ready, blend_ready;
  logic [ROW_W-1:0]         pos_r, pos_nr;
  logic [COL_W-1:0]         pos_c, pos_nc;
  logic [FRAC_BITS-1:0]     pos_wr, pos_wc;
  logic signed [ELEV_W-1:0] pos_elev;
  logic [ELEV_W-1:0]        grid_q [4];
  logic [WP_W-1:0]          grid_w [4];
  logic [3:0]               grid_par;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      south_r  <= '0;
      north_r  <= COORD_W'(4194304);
      west_r   <= '0;
      east_r   <= COORD_W'(4194304);
      inv_r    <= INV_W'(16777216);
      rows_r   <= CNT_W'(256);
      cols_r   <= CNT_W'(256);
      nodata_r <= ELEV_W'(-9999);
    end else if (cfg_wr_en) begin
      case (cfg_reg_e'(cfg_index))
        REG_SOUTH_LAT: south_r  <= cfg_data[COORD_W-1:0];
        REG_NORTH_LAT: north_r  <= cfg_data[COORD_W-1:0];
        REG_WEST_LON:  west_r   <= cfg_data[COORD_W-1:0];
        REG_EAST_LON:  east_r   <= cfg_data[COORD_W-1:0];
        REG_INV_CELL:  inv_r    <= cfg_data[INV_W-1:0];
        REG_NUM_ROWS:  rows_r   <= cfg_data[CNT_W-1:0];
        REG_NUM_COLS:  cols_r   <= cfg_data[CNT_W-1:0];
        REG_NODATA:    nodata_r <= cfg_data[ELEV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (rows_r == '0) begin
      last_row = '0;
    end else if (32'(rows_r) > 32'(MAX_ROWS)) begin
      last_row = ROW_W'(MAX_ROWS - 1);
    end else begin
      last_row = ROW_W'(32'(rows_r) - 32'd1);
    end
    if (cols_r == '0) begin
      last_col = '0;
    end else if (32'(cols_r) > 32'(MAX_COLS)) begin
      last_col = COL_W'(MAX_COLS - 1);
    end else begin
      last_col = COL_W'(32'(cols_r) - 32'd1);
    end
  end

  egbl_pos #(
    .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .FRAC_BITS(FRAC_BITS)
  ) u_pos (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_op(in_ch.op),
    .in_lat(in_ch.lat), .in_lon(in_ch.lon), .in_cell_row(in_ch.cell_row),
    .in_cell_col(in_ch.cell_col), .in_elevation(in_ch.elevation),
    .south_lat(south_r), .north_lat(north_r), .west_lon(west_r), .east_lon(east_r),
    .inv_cell_size(inv_r), .last_row, .last_col,
    .dn_ready(grid_ready), .out_ctl(pos_ctl),
    .out_r(pos_r), .out_nr(pos_nr), .out_c(pos_c), .out_nc(pos_nc),
    .out_wr(pos_wr), .out_wc(pos_wc), .out_elev(pos_elev)
  );

  egbl_grid #(
    .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .FRAC_BITS(FRAC_BITS)
  ) u_grid (
    .clk, .rst_n,
    .in_ctl(pos_ctl), .in_ready(grid_ready),
    .in_r(pos_r), .in_nr(pos_nr), .in_c(pos_c), .in_nc(pos_nc),
    .in_wr(pos_wr), .in_wc(pos_wc), .in_elev(pos_elev),
    .dn_ready(blend_ready), .out_ctl(grid_ctl),
    .out_q(grid_q), .out_w(grid_w), .out_par(grid_par)
  );

  egbl_blend #(
    .FRAC_BITS(FRAC_BITS)
  ) u_blend (
    .clk, .rst_n,
    .in_ctl(grid_ctl), .in_ready(blend_ready),
    .in_q(grid_q), .in_w(grid_w), .in_par(grid_par),
    .nodata_value(nodata_r),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_altitude(out_ch.altitude), .out_outside(out_ch.outside)
  );

endmodule
`default_nettype wire

// ----- sv/egbl_pos.sv -----
// Position front end: bounds test, edge offsets, reciprocal multiply and
// index/weight split. Three register stages. Depends on egbl_pkg.
`default_nettype none
module egbl_pos import egbl_pkg::*; #(
  parameter int MAX_ROWS  = MAX_ROWS_DEF,
  parameter int MAX_COLS  = MAX_COLS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire  [OP_W-1:0]           in_op,
  input  wire  signed [COORD_W-1:0] in_lat,
  input  wire  signed [COORD_W-1:0] in_lon,
  input  wire  [CELL_W-1:0]         in_cell_row,
  input  wire  [CELL_W-1:0]         in_cell_col,
  input  wire  signed [ELEV_W-1:0]  in_elevation,
  input  wire  signed [COORD_W-1:0] south_lat,
  input  wire  signed [COORD_W-1:0] north_lat,
  input  wire  signed [COORD_W-1:0] west_lon,
  input  wire  signed [COORD_W-1:0] east_lon,
  input  wire  [INV_W-1:0]          inv_cell_size,
  input  wire  [ROW_W-1:0]          last_row,
  input  wire  [COL_W-1:0]          last_col,
  input  wire                       dn_ready,
  output ctl_t                      out_ctl,
  output logic [ROW_W-1:0]          out_r,
  output logic [ROW_W-1:0]          out_nr,
  output logic [COL_W-1:0]          out_c,
  output logic [COL_W-1:0]          out_nc,
  output logic [FRAC_BITS-1:0]      out_wr,
  output logic [FRAC_BITS-1:0]      out_wc,
  output logic signed [ELEV_W-1:0]  out_elev
);

  localparam int IP_W = POS_W - POS_SHIFT + 1;

  logic en_a, en_b, en_c;

  ctl_t                     ctl_a_r, ctl_a_nxt, ctl_b_r, ctl_c_r;
  logic [COORD_W-1:0]       drow_a_r, dcol_a_r;
  logic [ROW_W-1:0]         wrow_a_r, wrow_b_r;
  logic [COL_W-1:0]         wcol_a_r, wcol_b_r;
  logic signed [ELEV_W-1:0] elev_a_r, elev_b_r, elev_c_r;
  logic [POS_W-1:0]         rpos_b_r, cpos_b_r;
  logic [ROW_W-1:0]         r_c_r, nr_c_r, r_nxt, nr_nxt;
  logic [COL_W-1:0]         c_c_r, nc_c_r, c_nxt, nc_nxt;
  logic [FRAC_BITS-1:0]     wr_c_r, wc_c_r, wr_nxt, wc_nxt;

  logic                     in_box, known;
  logic [COORD_W:0]         drow_full, dcol_full;
  logic [31:0]              row32, col32;
  op_e                      op_in;

  logic [POS_W:0]           rsum, csum;
  logic [IP_W-1:0]          rip, cip, rrnd, crnd, lr_ext, lc_ext;

  assign en_c     = !ctl_c_r.vld || dn_ready;
  assign en_b     = !ctl_b_r.vld || en_c;
  assign en_a     = !ctl_a_r.vld || en_b;
  assign in_ready = en_a && rst_n;

  always_comb begin
    op_in  = op_e'(in_op);
    known  = (op_in == OP_WRITE) || (op_in == OP_NEAREST) || (op_in == OP_BILINEAR);
    in_box = (in_lat >= south_lat) && (in_lat < north_lat) &&
             (in_lon >= west_lon) && (in_lon < east_lon);
    drow_full = {north_lat[COORD_W-1], north_lat} - {in_lat[COORD_W-1], in_lat};
    dcol_full = {in_lon[COORD_W-1], in_lon} - {west_lon[COORD_W-1], west_lon};
    row32 = 32'(in_cell_row);
    col32 = 32'(in_cell_col);
    ctl_a_nxt.vld     = in_valid && known;
    ctl_a_nxt.op      = op_in;
    ctl_a_nxt.outside = !in_box;
    ctl_a_nxt.wr_en   = (row32 < 32'(MAX_ROWS)) && (col32 < 32'(MAX_COLS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
      ctl_c_r <= '0;
    end else begin
      if (en_a) ctl_a_r <= ctl_a_nxt;
      if (en_b) ctl_b_r <= ctl_a_r;
      if (en_c) ctl_c_r <= ctl_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      drow_a_r <= drow_full[COORD_W-1:0];
      dcol_a_r <= dcol_full[COORD_W-1:0];
      wrow_a_r <= row32[ROW_W-1:0];
      wcol_a_r <= col32[COL_W-1:0];
      elev_a_r <= in_elevation;
    end
    if (en_b) begin
      rpos_b_r <= POS_W'(drow_a_r) * POS_W'(inv_cell_size);
      cpos_b_r <= POS_W'(dcol_a_r) * POS_W'(inv_cell_size);
      wrow_b_r <= wrow_a_r;
      wcol_b_r <= wcol_a_r;
      elev_b_r <= elev_a_r;
    end
    if (en_c) begin
      r_c_r    <= r_nxt;
      nr_c_r   <= nr_nxt;
      c_c_r    <= c_nxt;
      nc_c_r   <= nc_nxt;
      wr_c_r   <= wr_nxt;
      wc_c_r   <= wc_nxt;
      elev_c_r <= elev_b_r;
    end
  end

  always_comb begin
    rsum   = {1'b0, rpos_b_r} + ((POS_W+1)'(1) << (POS_SHIFT - 1));
    csum   = {1'b0, cpos_b_r} + ((POS_W+1)'(1) << (POS_SHIFT - 1));
    rip    = {1'b0, rpos_b_r[POS_W-1:POS_SHIFT]};
    cip    = {1'b0, cpos_b_r[POS_W-1:POS_SHIFT]};
    rrnd   = rsum[POS_W:POS_SHIFT];
    crnd   = csum[POS_W:POS_SHIFT];
    lr_ext = IP_W'(last_row);
    lc_ext = IP_W'(last_col);
    wr_nxt = '0;
    wc_nxt = '0;
    case (ctl_b_r.op)
      OP_WRITE: begin
        r_nxt = wrow_b_r;
        c_nxt = wcol_b_r;
      end
      OP_NEAREST: begin
        r_nxt = (rrnd >= lr_ext) ? last_row : rrnd[ROW_W-1:0];
        c_nxt = (crnd >= lc_ext) ? last_col : crnd[COL_W-1:0];
      end
      default: begin
        if (rip >= lr_ext) begin
          r_nxt = last_row;
        end else begin
          r_nxt  = rip[ROW_W-1:0];
          wr_nxt = rpos_b_r[POS_SHIFT-1 -: FRAC_BITS];
        end
        if (cip >= lc_ext) begin
          c_nxt = last_col;
        end else begin
          c_nxt  = cip[COL_W-1:0];
          wc_nxt = cpos_b_r[POS_SHIFT-1 -: FRAC_BITS];
        end
      end
    endcase
    if (ctl_b_r.op == OP_BILINEAR) begin
      nr_nxt = (r_nxt == last_row) ? r_nxt : r_nxt + ROW_W'(1);
      nc_nxt = (c_nxt == last_col) ? c_nxt : c_nxt + COL_W'(1);
    end else begin
      nr_nxt = r_nxt;
      nc_nxt = c_nxt;
    end
  end

  assign out_ctl  = ctl_c_r;
  assign out_r    = r_c_r;
  assign out_nr   = nr_c_r;
  assign out_c    = c_c_r;
  assign out_nc   = nc_c_r;
  assign out_wr   = wr_c_r;
  assign out_wc   = wc_c_r;
  assign out_elev = elev_c_r;

endmodule
`default_nettype wire

// ----- sv/egbl_grid.sv -----
// Sample store in four banks split by row and column parity, so the four
// bilinear neighbours read in the same cycle; also forms the corner weights.
// Depends on egbl_pkg.
`default_nettype none
module egbl_grid import egbl_pkg::*; #(
  parameter int MAX_ROWS  = MAX_ROWS_DEF,
  parameter int MAX_COLS  = MAX_COLS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int WP_W  = 2 * FRAC_BITS + 2
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  ctl_t                     in_ctl,
  output logic                     in_ready,
  input  wire  [ROW_W-1:0]         in_r,
  input  wire  [ROW_W-1:0]         in_nr,
  input  wire  [COL_W-1:0]         in_c,
  input  wire  [COL_W-1:0]         in_nc,
  input  wire  [FRAC_BITS-1:0]     in_wr,
  input  wire  [FRAC_BITS-1:0]     in_wc,
  input  wire  signed [ELEV_W-1:0] in_elev,
  input  wire                      dn_ready,
  output ctl_t                     out_ctl,
  output logic [ELEV_W-1:0]        out_q [4],
  output logic [WP_W-1:0]          out_w [4],
  output logic [3:0]               out_par
);

  localparam int HALF_ROWS = (MAX_ROWS + 1) / 2;
  localparam int HALF_COLS = (MAX_COLS + 1) / 2;
  localparam int DEPTH     = HALF_ROWS * HALF_COLS;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ONE_W     = FRAC_BITS + 1;

  logic              en_d;
  logic              do_write;
  ctl_t              ctl_d_r, ctl_d_nxt;
  logic [WP_W-1:0]   w_r [4];
  logic [3:0]        par_r;
  logic [ONE_W-1:0]  wr_hi, wr_lo, wc_hi, wc_lo;

  assign en_d     = !ctl_d_r.vld || dn_ready;
  assign in_ready = en_d;
  assign do_write = in_ctl.vld && (in_ctl.op == OP_WRITE) && in_ctl.wr_en;

  for (genvar p = 0; p < 2; p++) begin : g_row
    for (genvar q = 0; q < 2; q++) begin : g_col
      logic [ELEV_W-1:0] mem [DEPTH];
      logic [ELEV_W-1:0] rd_r;
      logic [ROW_W-1:0]  rsel;
      logic [COL_W-1:0]  csel;
      logic [AW-1:0]     addr;
      logic              bank_we;

      always_comb begin
        rsel    = (in_r[0] == 1'(p)) ? in_r : in_nr;
        csel    = (in_c[0] == 1'(q)) ? in_c : in_nc;
        addr    = AW'(32'(rsel >> 1) * HALF_COLS + 32'(csel >> 1));
        bank_we = do_write && (in_r[0] == 1'(p)) && (in_c[0] == 1'(q));
      end

      always_ff @(posedge clk) begin
        if (en_d) begin
          if (bank_we) mem[addr] <= in_elev;
          rd_r <= mem[addr];
        end
      end

      assign out_q[2*p+q] = rd_r;
    end
  end

  always_comb begin
    wr_lo = ONE_W'(in_wr);
    wc_lo = ONE_W'(in_wc);
    wr_hi = (ONE_W'(1) << FRAC_BITS) - wr_lo;
    wc_hi = (ONE_W'(1) << FRAC_BITS) - wc_lo;
    ctl_d_nxt     = in_ctl;
    ctl_d_nxt.vld = in_ctl.vld && (in_ctl.op != OP_WRITE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_d_r <= '0;
    end else if (en_d) begin
      ctl_d_r <= ctl_d_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      w_r[0] <= WP_W'(wr_hi) * WP_W'(wc_hi);
      w_r[1] <= WP_W'(wr_hi) * WP_W'(wc_lo);
      w_r[2] <= WP_W'(wr_lo) * WP_W'(wc_hi);
      w_r[3] <= WP_W'(wr_lo) * WP_W'(wc_lo);
      par_r  <= {in_r[0], in_nr[0], in_c[0], in_nc[0]};
    end
  end

  assign out_ctl = ctl_d_r;
  assign out_w   = w_r;
  assign out_par = par_r;

endmodule
`default_nettype wire

// ----- sv/egbl_blend.sv -----
// Blend back end: corner products, sum, rounding, bias removal, nearest or
// nodata selection and saturation into the output register. Depends on egbl_pkg.
`default_nettype none
module egbl_blend import egbl_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int WP_W = 2 * FRAC_BITS + 2
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  ctl_t                     in_ctl,
  output logic                     in_ready,
  input  wire  [ELEV_W-1:0]        in_q [4],
  input  wire  [WP_W-1:0]          in_w [4],
  input  wire  [3:0]               in_par,
  input  wire  signed [ELEV_W-1:0] nodata_value,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic signed [ALT_W-1:0]  out_altitude,
  output logic                     out_outside
);

  localparam int PR_W  = WP_W + ELEV_W;
  localparam int SUM_W = PR_W + 2;
  localparam int SH_W  = SUM_W - FRAC_BITS;
  localparam int SW    = SH_W + 2;

  logic en_e, en_f;

  ctl_t                     ctl_e_r;
  logic                     vld_f_r;
  logic [PR_W-1:0]          prod_r [4];
  logic [PR_W-1:0]          prod_nxt [4];
  logic signed [ELEV_W-1:0] near_r;
  logic signed [ALT_W-1:0]  alt_r, alt_nxt;
  logic                     outside_r;

  logic [1:0]               sel [4];
  logic [ELEV_W-1:0]        ub;
  logic [SUM_W-1:0]         sum, rnd;
  logic signed [SW-1:0]     blend, scaled;

  assign en_f     = !vld_f_r || out_ready;
  assign en_e     = !ctl_e_r.vld || en_f;
  assign in_ready = en_e;

  always_comb begin
    sel[0] = {in_par[3], in_par[1]};
    sel[1] = {in_par[3], in_par[0]};
    sel[2] = {in_par[2], in_par[1]};
    sel[3] = {in_par[2], in_par[0]};
    for (int k = 0; k < 4; k++) begin
      ub = {~in_q[sel[k]][ELEV_W-1], in_q[sel[k]][ELEV_W-2:0]};
      prod_nxt[k] = (in_w[k] == '0) ? '0 : PR_W'(in_w[k]) * PR_W'(ub);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_e_r <= '0;
      vld_f_r <= 1'b0;
    end else begin
      if (en_e) ctl_e_r <= in_ctl;
      if (en_f) vld_f_r <= ctl_e_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en_e) begin
      prod_r <= prod_nxt;
      near_r <= in_q[sel[0]];
    end
    if (en_f) begin
      alt_r     <= alt_nxt;
      outside_r <= ctl_e_r.outside;
    end
  end

  always_comb begin
    sum = SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) + SUM_W'(prod_r[2]) + SUM_W'(prod_r[3]);
    rnd = sum + (SUM_W'(1) << (FRAC_BITS - 1));
    blend = $signed({2'b00, rnd[SUM_W-1:FRAC_BITS]}) - (SW'(32768) << FRAC_BITS);
    if (ctl_e_r.outside) begin
      scaled = SW'(nodata_value) <<< FRAC_BITS;
    end else if (ctl_e_r.op == OP_NEAREST) begin
      scaled = SW'(near_r) <<< FRAC_BITS;
    end else begin
      scaled = blend;
    end
    if (scaled > SW'(ALT_MAX)) begin
      alt_nxt = ALT_W'(ALT_MAX);
    end else if (scaled < SW'(ALT_MIN)) begin
      alt_nxt = ALT_W'(ALT_MIN);
    end else begin
      alt_nxt = scaled[ALT_W-1:0];
    end
  end

  assign out_valid    = vld_f_r;
  assign out_altitude = alt_r;
  assign out_outside  = outside_r;

endmodule
`default_nettype wire

// ----- sv/egbl_checker.sv -----
// Port-level checks for the elevation grid lookup core, bound to the top.
// Depends on egbl_pkg and elevation_grid_bilinear_lookup_core.
`default_nettype none
module egbl_checker import egbl_pkg::*; (
  input wire                    clk,
  input wire                    rst_n,
  input wire                    in_ready,
  input wire                    out_valid,
  input wire                    out_ready,
  input wire signed [ALT_W-1:0] out_altitude
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_altitude)))
    else $error("result dropped or changed while stalled");

  a_no_ready_in_reset: assert property (@(posedge clk)
    !rst_n |-> !in_ready)
    else $error("request taken during reset");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) &&
                   $past(rst_n, 4) && $past(rst_n, 5) && $past(rst_n, 6)))
    else $error("result sooner than pipeline latency after reset");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind elevation_grid_bilinear_lookup_core egbl_checker u_egbl_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_altitude (out_ch.altitude)
);
`default_nettype wire
